### src/bhsl_pkg.sv
// ----------------------------------------------------------------------------
// bhsl_pkg: shared types and codes for the button hold and status LED block
// Holds result codes, the configuration register map and the timer reload rule.
// ----------------------------------------------------------------------------
package bhsl_pkg;

  // Configuration register map
  localparam logic [3:0] CFG_SCAN_PERIOD      = 4'd0;
  localparam logic [3:0] CFG_SHORT_FLOOR      = 4'd1;
  localparam logic [3:0] CFG_CALIB_THRESHOLD  = 4'd2;
  localparam logic [3:0] CFG_PAIR_THRESHOLD   = 4'd3;
  localparam logic [3:0] CFG_BLINK_PERIOD     = 4'd4;
  localparam logic [3:0] CFG_CHASE_PERIOD     = 4'd5;
  localparam logic [3:0] CFG_ALTERNATE_PERIOD = 4'd6;
  localparam logic [3:0] CFG_HEARTBEAT_PERIOD = 4'd7;

  // Button release classes
  localparam logic [1:0] CMD_NONE      = 2'd0;
  localparam logic [1:0] CMD_SHORT     = 2'd1;
  localparam logic [1:0] CMD_CALIBRATE = 2'd2;
  localparam logic [1:0] CMD_PAIR      = 2'd3;

  // Hold zones
  localparam logic [1:0] ZONE_NONE      = 2'd0;
  localparam logic [1:0] ZONE_CALIBRATE = 2'd1;
  localparam logic [1:0] ZONE_PAIR      = 2'd2;

  // Calibrator status codes
  localparam logic [1:0] STAT_DONE   = 2'd0;
  localparam logic [1:0] STAT_NEEDS  = 2'd1;
  localparam logic [1:0] STAT_ORIGIN = 2'd2;
  localparam logic [1:0] STAT_RANGE  = 2'd3;

  // Display modes
  localparam logic [2:0] MODE_NORMAL   = 3'd0;
  localparam logic [2:0] MODE_NEEDS    = 3'd1;
  localparam logic [2:0] MODE_READY    = 3'd2;
  localparam logic [2:0] MODE_STEP_ONE = 3'd3;
  localparam logic [2:0] MODE_STEP_TWO = 3'd4;

  // LED patterns
  localparam logic [3:0] LED_ALL_OFF = 4'h0;
  localparam logic [3:0] LED_ALL_ON  = 4'hF;
  localparam logic [3:0] LED_PAIR_LO = 4'h3;
  localparam logic [3:0] LED_ALT_A   = 4'h7;
  localparam logic [3:0] LED_ALT_B   = 4'hB;

  localparam logic [15:0] HOLD_MAX = 16'hFFFF;

  // Timer reload: period minus one, a zero period fires every tick
  function automatic logic [9:0] reload_of(input logic [9:0] period);
    logic [9:0] res;
    res = (period == 10'd0) ? 10'd0 : period - 10'd1;
    return res;
  endfunction

endpackage

### src/button_hold_and_status_led_controller.sv
// ----------------------------------------------------------------------------
// button_hold_and_status_led_controller: button, switch and status LED logic
// Debounces the mode switch, classifies button holds and sequences four LEDs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one beat per millisecond tick with the
//   raw switch level, raw button level and calibrator status.
//   Result channel (out_valid / out_stall): one beat per input beat carrying
//   the LED bits, debounced switch, release class, hold zone, display mode and
//   the start-calibration pulse.
//   Configuration: cfg_we writes cfg_wdata into register cfg_index; unknown
//   indexes are ignored. The user makes writes while no beat is in flight.
//   The block itself does not enforce this.
// Pipeline: a beat is captured in the input register; the whole tick update
//   is combinational from there into the state and output registers.
//   One beat is taken every cycle while out_stall is low.
// Reset: rst_n (synchronous) empties both registers, loads the default
//   periods and thresholds and clears timers, counters and LEDs.
// Stall: while out_stall holds a waiting result, the input register still
//   takes one more beat; after that in_stall rises until the result leaves.
// ----------------------------------------------------------------------------
module button_hold_and_status_led_controller
  import bhsl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_switch_level,
  input  logic        in_button_level,
  input  logic [1:0]  in_calib_status,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_led_bits,
  output logic        out_switch_on,
  output logic [1:0]  out_button_command,
  output logic [1:0]  out_hold_zone,
  output logic [2:0]  out_display_mode,
  output logic        out_start_calibration
);

  // configuration registers
  logic [9:0]  scan_period_r, blink_period_r, chase_period_r;
  logic [9:0]  alternate_period_r, heartbeat_period_r;
  logic [15:0] short_floor_r, calib_thr_r, pair_thr_r;

  // input register
  logic       s1_valid_r;
  logic       s1_switch_r, s1_button_r;
  logic [1:0] s1_status_r;

  // tick state
  logic [9:0]  scan_timer_r, scan_timer_nxt;
  logic [9:0]  led_timer_r, led_timer_nxt;
  logic        sw_level_r, sw_level_nxt;
  logic        sw_pend_r, sw_pend_nxt;
  logic        sw_on_r, sw_on_nxt;
  logic [15:0] hold_r, hold_nxt;
  logic [1:0]  cmd_r, cmd_nxt;
  logic [1:0]  zone_r, zone_nxt;
  logic [1:0]  led_step_r, led_step_nxt;
  logic [3:0]  led_reg_r, led_reg_nxt;

  // output register
  logic       out_valid_r;
  logic [2:0] mode_out_r;
  logic       pulse_out_r;

  logic       adv;
  logic       scan_due, led_due;
  logic       pulse;
  logic [1:0] status_eff;
  logic [2:0] mode;
  logic [9:0] led_period;
  logic [2:0] hb_next;

  // handshake: the update runs when the input register has a beat and
  // the output register is free or draining
  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_period_r      <= 10'd10;
      short_floor_r      <= 16'd2;
      calib_thr_r        <= 16'd200;
      pair_thr_r         <= 16'd400;
      blink_period_r     <= 10'd300;
      chase_period_r     <= 10'd50;
      alternate_period_r <= 10'd100;
      heartbeat_period_r <= 10'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCAN_PERIOD:      scan_period_r      <= cfg_wdata[9:0];
        CFG_SHORT_FLOOR:      short_floor_r      <= cfg_wdata;
        CFG_CALIB_THRESHOLD:  calib_thr_r        <= cfg_wdata;
        CFG_PAIR_THRESHOLD:   pair_thr_r         <= cfg_wdata;
        CFG_BLINK_PERIOD:     blink_period_r     <= cfg_wdata[9:0];
        CFG_CHASE_PERIOD:     chase_period_r     <= cfg_wdata[9:0];
        CFG_ALTERNATE_PERIOD: alternate_period_r <= cfg_wdata[9:0];
        CFG_HEARTBEAT_PERIOD: heartbeat_period_r <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!s1_valid_r || adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_switch_r <= in_switch_level;
      s1_button_r <= in_button_level;
      s1_status_r <= in_calib_status;
    end
  end

  // scan: switch debounce, hold count, release class and zone
  always_comb begin
    scan_due       = (scan_timer_r == 10'd0);
    scan_timer_nxt = scan_due ? reload_of(scan_period_r) : scan_timer_r - 10'd1;
    sw_level_nxt   = sw_level_r;
    sw_pend_nxt    = sw_pend_r;
    sw_on_nxt      = sw_on_r;
    hold_nxt       = hold_r;
    cmd_nxt        = cmd_r;
    zone_nxt       = zone_r;
    pulse          = 1'b0;
    if (scan_due) begin
      // two differing scans, not necessarily in a row, accept the new level
      if (s1_switch_r != sw_level_r) begin
        if (!sw_pend_r) begin
          sw_pend_nxt = 1'b1;
        end else begin
          sw_pend_nxt  = 1'b0;
          sw_on_nxt    = ~s1_switch_r;
          sw_level_nxt = s1_switch_r;
        end
      end
      if (!s1_button_r) begin
        if (hold_r != HOLD_MAX) hold_nxt = hold_r + 16'd1;
      end else begin
        if (hold_r > short_floor_r && hold_r < calib_thr_r) begin
          cmd_nxt = CMD_SHORT;
        end else if (hold_r >= calib_thr_r && hold_r < pair_thr_r) begin
          cmd_nxt = CMD_CALIBRATE;
          pulse   = 1'b1;
        end else if (hold_r >= pair_thr_r) begin
          cmd_nxt = CMD_PAIR;
        end else begin
          cmd_nxt = CMD_NONE;
        end
        hold_nxt = 16'd0;
      end
      if (hold_nxt >= calib_thr_r && hold_nxt < pair_thr_r) begin
        zone_nxt = ZONE_CALIBRATE;
      end else if (hold_nxt >= pair_thr_r) begin
        zone_nxt = ZONE_PAIR;
      end else begin
        zone_nxt = ZONE_NONE;
      end
    end
  end

  // display mode priority mux; the start pulse forces the origin step
  always_comb begin
    status_eff = pulse ? STAT_ORIGIN : s1_status_r;
    if (zone_nxt == ZONE_CALIBRATE)    mode = MODE_READY;
    else if (status_eff == STAT_ORIGIN) mode = MODE_STEP_ONE;
    else if (status_eff == STAT_RANGE)  mode = MODE_STEP_TWO;
    else if (status_eff == STAT_NEEDS)  mode = MODE_NEEDS;
    else                                mode = MODE_NORMAL;
  end

  // LED sequencer
  always_comb begin
    led_due      = (led_timer_r == 10'd0);
    led_step_nxt = led_step_r;
    led_reg_nxt  = led_reg_r;
    hb_next      = {1'b0, led_step_r} + 3'd1;
    unique case (mode)
      MODE_NEEDS: begin
        led_period = blink_period_r;
        if (led_step_r != 2'd0) begin
          led_step_nxt = 2'd0;
          led_reg_nxt  = LED_ALL_ON;
        end else begin
          led_step_nxt = 2'd1;
          led_reg_nxt  = LED_ALL_OFF;
        end
      end
      MODE_READY: begin
        led_period   = chase_period_r;
        led_reg_nxt  = 4'b0001 << led_step_r;
        led_step_nxt = led_step_r + 2'd1;
      end
      MODE_STEP_ONE: begin
        led_period  = heartbeat_period_r;
        led_reg_nxt = LED_PAIR_LO;
      end
      MODE_STEP_TWO: begin
        led_period = alternate_period_r;
        if (led_step_r != 2'd0) begin
          led_step_nxt = 2'd0;
          led_reg_nxt  = LED_ALT_B;
        end else begin
          led_step_nxt = 2'd1;
          led_reg_nxt  = LED_ALT_A;
        end
      end
      default: begin
        // heartbeat: on for the last two steps of four
        led_period   = heartbeat_period_r;
        led_reg_nxt  = (hb_next >= 3'd3) ? LED_PAIR_LO : LED_ALL_OFF;
        led_step_nxt = (hb_next >= 3'd4) ? 2'd0 : hb_next[1:0];
      end
    endcase
    if (!led_due) begin
      led_step_nxt = led_step_r;
      led_reg_nxt  = led_reg_r;
    end
    led_timer_nxt = led_due ? reload_of(led_period) : led_timer_r - 10'd1;
  end

  // state update, one tick per beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_timer_r <= 10'd0;
      led_timer_r  <= 10'd0;
      sw_level_r   <= 1'b0;
      sw_pend_r    <= 1'b0;
      sw_on_r      <= 1'b0;
      hold_r       <= 16'd0;
      cmd_r        <= CMD_NONE;
      zone_r       <= ZONE_NONE;
      led_step_r   <= 2'd0;
      led_reg_r    <= LED_ALL_OFF;
    end else if (adv) begin
      scan_timer_r <= scan_timer_nxt;
      led_timer_r  <= led_timer_nxt;
      sw_level_r   <= sw_level_nxt;
      sw_pend_r    <= sw_pend_nxt;
      sw_on_r      <= sw_on_nxt;
      hold_r       <= hold_nxt;
      cmd_r        <= cmd_nxt;
      zone_r       <= zone_nxt;
      led_step_r   <= led_step_nxt;
      led_reg_r    <= led_reg_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode_out_r  <= mode;
      pulse_out_r <= pulse;
    end
  end

  // state registers hold the latest result until the next beat advances
  assign out_valid             = out_valid_r;
  assign out_led_bits          = led_reg_r;
  assign out_switch_on         = sw_on_r;
  assign out_button_command    = cmd_r;
  assign out_hold_zone         = zone_r;
  assign out_display_mode      = mode_out_r;
  assign out_start_calibration = pulse_out_r;

endmodule

### verif/button_hold_and_status_led_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button hold and status LED checker
// Watches the configuration port and both channels of the controller. Every
// accepted input beat is run through a cycle-free model of one millisecond
// tick; every accepted result beat is compared field by field with the oldest
// predicted tick.
// ----------------------------------------------------------------------------
module button_hold_and_status_led_checker
  import bhsl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_switch_level,
  input  logic        in_button_level,
  input  logic [1:0]  in_calib_status,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  out_led_bits,
  input  logic        out_switch_on,
  input  logic [1:0]  out_button_command,
  input  logic [1:0]  out_hold_zone,
  input  logic [2:0]  out_display_mode,
  input  logic        out_start_calibration,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic [3:0] led;
    logic       sw_on;
    logic [1:0] cmd;
    logic [1:0] zone;
    logic [2:0] mode;
    logic       start;
  } tick_result_t;

  // Shadow copy of the configuration registers
  logic [9:0]  scan_per, blink_per, chase_per, alt_per, heart_per;
  logic [15:0] short_floor, calib_thr, pair_thr;

  // Model state
  logic [9:0]  scan_cnt, led_cnt;
  logic        sw_level_q, sw_pending_q, sw_on_q;
  logic [15:0] hold_q;
  logic [1:0]  cmd_q, zone_q, step_q;
  logic [3:0]  led_q;

  tick_result_t expected_ticks[$];
  tick_result_t want_tick;
  int           errors_seen = 0;

  assign fail_count = errors_seen;

  task automatic reset_model();
    scan_per     = 10'd10;
    short_floor  = 16'd2;
    calib_thr    = 16'd200;
    pair_thr     = 16'd400;
    blink_per    = 10'd300;
    chase_per    = 10'd50;
    alt_per      = 10'd100;
    heart_per    = 10'd10;
    scan_cnt     = '0;
    led_cnt      = '0;
    sw_level_q   = 1'b0;
    sw_pending_q = 1'b0;
    sw_on_q      = 1'b0;
    hold_q       = '0;
    cmd_q        = CMD_NONE;
    zone_q       = ZONE_NONE;
    step_q       = '0;
    led_q        = LED_ALL_OFF;
  endtask

  task automatic write_shadow(input logic [3:0] idx, input logic [15:0] val);
    case (idx)
      CFG_SCAN_PERIOD:      scan_per    = val[9:0];
      CFG_SHORT_FLOOR:      short_floor = val;
      CFG_CALIB_THRESHOLD:  calib_thr   = val;
      CFG_PAIR_THRESHOLD:   pair_thr    = val;
      CFG_BLINK_PERIOD:     blink_per   = val[9:0];
      CFG_CHASE_PERIOD:     chase_per   = val[9:0];
      CFG_ALTERNATE_PERIOD: alt_per     = val[9:0];
      CFG_HEARTBEAT_PERIOD: heart_per   = val[9:0];
      default: ;
    endcase
  endtask

  // One millisecond tick: scan, mode mux, LED sequencer
  function automatic tick_result_t predict_tick(input logic sw, input logic btn,
                                                input logic [1:0] st);
    tick_result_t r;
    logic         start;
    logic [2:0]   mode;
    logic [9:0]   per;
    logic [2:0]   nxt;
    start = 1'b0;

    // scan: switch debounce, hold counting, release class, zone
    if (scan_cnt == 10'd0) begin
      scan_cnt = (scan_per == 10'd0) ? 10'd0 : scan_per - 10'd1;
      if (sw != sw_level_q) begin
        // a pending change survives a bounce back; the next differing scan takes it
        if (!sw_pending_q) begin
          sw_pending_q = 1'b1;
        end else begin
          sw_pending_q = 1'b0;
          sw_on_q      = ~sw;
          sw_level_q   = sw;
        end
      end
      if (!btn) begin
        if (hold_q != HOLD_MAX) hold_q = hold_q + 16'd1;
      end else begin
        // first match wins, even with misordered thresholds
        if (hold_q > short_floor && hold_q < calib_thr) begin
          cmd_q = CMD_SHORT;
        end else if (hold_q >= calib_thr && hold_q < pair_thr) begin
          cmd_q = CMD_CALIBRATE;
          start = 1'b1;
        end else if (hold_q >= pair_thr) begin
          cmd_q = CMD_PAIR;
        end else begin
          cmd_q = CMD_NONE;
        end
        hold_q = '0;
      end
      if (hold_q >= calib_thr && hold_q < pair_thr) zone_q = ZONE_CALIBRATE;
      else if (hold_q >= pair_thr)                  zone_q = ZONE_PAIR;
      else                                          zone_q = ZONE_NONE;
    end else begin
      scan_cnt = scan_cnt - 10'd1;
    end

    // the start pulse forces the origin step on its own tick
    if (start) st = STAT_ORIGIN;

    if (zone_q == ZONE_CALIBRATE)  mode = MODE_READY;
    else if (st == STAT_ORIGIN)    mode = MODE_STEP_ONE;
    else if (st == STAT_RANGE)     mode = MODE_STEP_TWO;
    else if (st == STAT_NEEDS)     mode = MODE_NEEDS;
    else                           mode = MODE_NORMAL;

    // LED sequencer, reloaded with the period of the mode in force
    if (led_cnt == 10'd0) begin
      case (mode)
        MODE_NEEDS: begin
          per = blink_per;
          if (step_q != 2'd0) begin
            step_q = 2'd0;
            led_q  = LED_ALL_ON;
          end else begin
            step_q = 2'd1;
            led_q  = LED_ALL_OFF;
          end
        end
        MODE_READY: begin
          per    = chase_per;
          led_q  = 4'b0001 << step_q;
          step_q = step_q + 2'd1;
        end
        MODE_STEP_ONE: begin
          per   = heart_per;
          led_q = LED_PAIR_LO;
        end
        MODE_STEP_TWO: begin
          per = alt_per;
          if (step_q != 2'd0) begin
            step_q = 2'd0;
            led_q  = LED_ALT_B;
          end else begin
            step_q = 2'd1;
            led_q  = LED_ALT_A;
          end
        end
        default: begin
          per    = heart_per;
          nxt    = {1'b0, step_q} + 3'd1;
          led_q  = (nxt >= 3'd3) ? LED_PAIR_LO : LED_ALL_OFF;
          step_q = (nxt >= 3'd4) ? 2'd0 : nxt[1:0];
        end
      endcase
      led_cnt = (per == 10'd0) ? 10'd0 : per - 10'd1;
    end else begin
      led_cnt = led_cnt - 10'd1;
    end

    r.led   = led_q;
    r.sw_on = sw_on_q;
    r.cmd   = cmd_q;
    r.zone  = zone_q;
    r.mode  = mode;
    r.start = start;
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors_seen++;
      $display("time %0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Sample both channels at every edge; input beats push, result beats pop
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_model();
      expected_ticks.delete();
    end else begin
      if (cfg_we) write_shadow(cfg_index, cfg_wdata);
      if (in_valid && !in_stall)
        expected_ticks.push_back(predict_tick(in_switch_level, in_button_level,
                                              in_calib_status));
      if (out_valid && !out_stall) begin
        if (expected_ticks.size() == 0) begin
          errors_seen++;
          $display("time %0t: result beat with no tick outstanding, expected none, actual %h",
                   $time, {out_led_bits, out_switch_on, out_button_command,
                           out_hold_zone, out_display_mode, out_start_calibration});
        end else begin
          want_tick = expected_ticks.pop_front();
          check_field("led_bits",          int'(want_tick.led),   int'(out_led_bits));
          check_field("switch_on",         int'(want_tick.sw_on), int'(out_switch_on));
          check_field("button_command",    int'(want_tick.cmd),   int'(out_button_command));
          check_field("hold_zone",         int'(want_tick.zone),  int'(out_hold_zone));
          check_field("display_mode",      int'(want_tick.mode),  int'(out_display_mode));
          check_field("start_calibration", int'(want_tick.start),
                      int'(out_start_calibration));
        end
      end
    end
    pending_count = expected_ticks.size();
  end

endmodule

### verif/button_hold_and_status_led_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button hold and status LED controller testbench
// Drives millisecond ticks through the controller under several register
// settings and idle patterns: a short directed run, random press sequences
// around the hold thresholds, and one long hold released as a pair press.
// The checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module button_hold_and_status_led_controller_tb
  import bhsl_pkg::*;
();

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_index = CFG_SCAN_PERIOD;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_switch_level = 1'b1;
  logic        in_button_level = 1'b1;
  logic [1:0]  in_calib_status = STAT_DONE;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_led_bits;
  logic        out_switch_on;
  logic [1:0]  out_button_command;
  logic [1:0]  out_hold_zone;
  logic [2:0]  out_display_mode;
  logic        out_start_calibration;
  int          fail_count;
  int          pending_count;

  // idle percentages for each side
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // current register values, used to size press sequences
  int scan_cfg  = 10;
  int floor_cfg = 2;
  int calib_cfg = 200;
  int pair_cfg  = 400;

  // press sequence generator state
  int         press_left   = 0;
  int         release_left = 0;
  logic       noisy        = 1'b0;
  logic       sw_level     = 1'b1;
  logic [1:0] status_level = STAT_DONE;

  button_hold_and_status_led_controller uut (.*);
  button_hold_and_status_led_checker    u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // receiver stall
  always @(posedge clk)
    out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);

  // one tick beat, with random gaps before it
  task automatic send_tick(input logic sw, input logic btn, input logic [1:0] st);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_switch_level <= sw;
    in_button_level <= btn;
    in_calib_status <= st;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // wait until every predicted tick has come back, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_count == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [3:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[15:0];
    @(posedge clk);
  endtask

  task automatic configure(input int scan, input int flr, input int calib, input int pair,
                           input int blink, input int chase, input int alt, input int heart);
    drain();
    write_reg(CFG_SCAN_PERIOD,      scan);
    write_reg(CFG_SHORT_FLOOR,      flr);
    write_reg(CFG_CALIB_THRESHOLD,  calib);
    write_reg(CFG_PAIR_THRESHOLD,   pair);
    write_reg(CFG_BLINK_PERIOD,     blink);
    write_reg(CFG_CHASE_PERIOD,     chase);
    write_reg(CFG_ALTERNATE_PERIOD, alt);
    write_reg(CFG_HEARTBEAT_PERIOD, heart);
    cfg_we    <= 1'b0;
    scan_cfg  = scan;
    floor_cfg = flr;
    calib_cfg = calib;
    pair_cfg  = pair;
  endtask

  // Mostly whole presses sized to land near a threshold, some noise bursts
  task automatic random_ticks(input int count);
    int         base;
    int         holds;
    int         scan_eff;
    logic       btn;
    logic       sw;
    logic [1:0] st;
    scan_eff = (scan_cfg == 0) ? 1 : scan_cfg;
    for (int i = 0; i < count; i++) begin
      if (press_left == 0 && release_left == 0) begin
        noisy = ($urandom_range(9) < 2);
        case ($urandom_range(3))
          0:       base = floor_cfg;
          1:       base = calib_cfg;
          2:       base = pair_cfg;
          default: base = $urandom_range(20);
        endcase
        holds = base + int'($urandom_range(2)) - 1;
        if (holds < 0)  holds = 0;
        if (holds > 60) holds = 60;
        press_left = holds * scan_eff + int'($urandom_range(scan_eff - 1));
        if (press_left > 300) press_left = 300;
        release_left = $urandom_range(2 * scan_eff + 2, 1);
        if (release_left > 100) release_left = 100;
      end
      if (press_left > 0) begin
        btn = 1'b0;
        press_left--;
      end else begin
        btn = 1'b1;
        release_left--;
      end
      if (noisy) btn = 1'($urandom_range(1));

      // switch: occasional real change, occasional one-tick glitch
      if ($urandom_range(99) < 3) sw_level = ~sw_level;
      sw = sw_level;
      if ($urandom_range(99) < 5) sw = ~sw;

      // calibrator status: mostly steady, sometimes jumping
      if ($urandom_range(99) < 2) status_level = 2'($urandom_range(3));
      st = status_level;
      if ($urandom_range(99) < 5) st = 2'($urandom_range(3));

      send_tick(sw, btn, st);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults, all field extremes
    send_tick(1'b1, 1'b1, STAT_DONE);
    send_tick(1'b0, 1'b0, STAT_NEEDS);
    send_tick(1'b1, 1'b1, STAT_RANGE);
    send_tick(1'b0, 1'b1, STAT_ORIGIN);

    // scan every tick, tight thresholds
    configure(1, 1, 3, 5, 2, 1, 2, 1);
    // switch change that bounces back before it is taken
    send_tick(1'b1, 1'b1, STAT_DONE);
    send_tick(1'b0, 1'b1, STAT_NEEDS);
    send_tick(1'b1, 1'b1, STAT_NEEDS);
    send_tick(1'b0, 1'b1, STAT_RANGE);
    send_tick(1'b0, 1'b1, STAT_RANGE);
    // short press, then a released scan drops the command
    repeat (2) send_tick(1'b0, 1'b0, STAT_DONE);
    repeat (2) send_tick(1'b0, 1'b1, STAT_DONE);
    // calibrate press released while the status says range step
    repeat (4) send_tick(1'b0, 1'b0, STAT_RANGE);
    send_tick(1'b0, 1'b1, STAT_RANGE);
    // pair press
    repeat (6) send_tick(1'b0, 1'b0, STAT_NEEDS);
    send_tick(1'b0, 1'b1, STAT_NEEDS);

    // sender idles rarely, receiver often
    send_idle_pct = 13;
    recv_idle_pct = 71;
    configure(1, 2, 6, 12, 3, 2, 4, 1);
    random_ticks(250);
    configure(3, 0, 3, 7, 0, 1, 0, 2);
    random_ticks(200);

    // the other way round; misordered thresholds, zero and full periods
    send_idle_pct = 71;
    recv_idle_pct = 13;
    configure(2, 8, 10, 4, 5, 3, 1, 2);
    random_ticks(250);
    configure(0, 0, 0, 65535, 0, 1023, 1, 0);
    random_ticks(150);

    // no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure(1023, 65535, 65535, 0, 1023, 1023, 1023, 1023);
    random_ticks(150);
    configure(1, 1, 4, 9, 1, 1, 1, 1);
    random_ticks(150);

    // long hold through both zones, then release as a pair press
    configure(0, 0, 1, 16, 2, 2, 2, 2);
    repeat (20) send_tick(1'b0, 1'b0, STAT_DONE);
    repeat (3) send_tick(1'b0, 1'b1, STAT_DONE);

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

### button_hold_and_status_led_controller.f
src/bhsl_pkg.sv
src/button_hold_and_status_led_controller.sv
verif/button_hold_and_status_led_checker.sv
verif/button_hold_and_status_led_controller_tb.sv
